// ===== design/ossl_pkg.sv =====
// Package for the ordering swap local search unit.
// Holds widths, opcode codes, sequencer state type, write-port structs and helpers.
package ossl_pkg;

   localparam int NUM_VARS = 64;
   localparam int VAR_W    = 6;
   localparam int CNT_W    = 7;
   localparam int COST_W   = 32;
   localparam int SQ_W     = 12;
   localparam int DELTA_W  = 24;

   localparam logic [2:0] OP_SET_BIT   = 3'd0;
   localparam logic [2:0] OP_WRITE_SLOT = 3'd1;
   localparam logic [2:0] OP_EVAL      = 3'd2;
   localparam logic [2:0] OP_SWAP      = 3'd3;
   localparam logic [2:0] OP_READ_SLOT = 3'd4;

   localparam logic [CNT_W-1:0] ACTIVE_MIN = CNT_W'(2);
   localparam logic [CNT_W-1:0] ACTIVE_MAX = CNT_W'(NUM_VARS);

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROW_WR,
      S_SLOT_RD,
      S_EV_ORD,
      S_EV_ROW,
      S_EV_WALK,
      S_SW_RP,
      S_SW_RQ,
      S_SW_RX,
      S_SW_RY,
      S_SW_LY,
      S_SW_WALK,
      S_SW_FIN,
      S_SW_WP,
      S_SW_WQ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                en;
      logic [VAR_W-1:0]    addr;
      logic [NUM_VARS-1:0] data;
   } row_wr_type;

   typedef struct packed {
      logic             en;
      logic [VAR_W-1:0] addr;
      logic [VAR_W-1:0] data;
   } slot_wr_type;

   function automatic logic [SQ_W-1:0] square_dist(input logic [VAR_W-1:0] d);
      logic [2*VAR_W-1:0] prod;
      prod = d * d;
      return prod[SQ_W-1:0];
   endfunction

   function automatic logic [VAR_W-1:0] abs_diff(input logic [CNT_W-1:0] x,
                                                  input logic [CNT_W-1:0] y);
      logic [CNT_W-1:0] r;
      r = (x > y) ? (x - y) : (y - x);
      return r[VAR_W-1:0];
   endfunction

endpackage

// ===== design/ossl_infl_ram.sv =====
// Influence bit matrix: one 64-bit row per variable, one write and one read port.
// Per-row valid bits make never-written rows read as zero after reset. Uses ossl_pkg.
module ossl_infl_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  ossl_pkg::row_wr_type         row_wr,
   input  logic                         rd_en,
   input  logic [ossl_pkg::VAR_W-1:0]   rd_addr,
   output logic [ossl_pkg::NUM_VARS-1:0] rd_data
);
   import ossl_pkg::*;

   logic [NUM_VARS-1:0] mem [NUM_VARS];
   logic [NUM_VARS-1:0] valid_ff;
   logic [NUM_VARS-1:0] data_ff;
   logic                hit_ff;

   always_ff @(posedge clock) begin
      if (row_wr.en) begin
         mem[row_wr.addr] <= row_wr.data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (row_wr.en) begin
            valid_ff[row_wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// ===== design/ossl_slot_ram.sv =====
// Ordering slot store: one variable index per slot, one write and one read port.
// Contents are undefined until written. Uses ossl_pkg.
module ossl_slot_ram (
   input  logic                       clock,
   input  ossl_pkg::slot_wr_type      slot_wr,
   input  logic                       rd_en,
   input  logic [ossl_pkg::VAR_W-1:0] rd_addr,
   output logic [ossl_pkg::VAR_W-1:0] rd_data
);
   import ossl_pkg::*;

   logic [VAR_W-1:0] mem [NUM_VARS];
   logic [VAR_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (slot_wr.en) begin
         mem[slot_wr.addr] <= slot_wr.data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ===== design/ordering_swap_local_search_unit.sv =====
// Top level of the ordering swap local search unit: sequencer and cost datapath.
// Depends on ossl_pkg, ossl_infl_ram and ossl_slot_ram.
//
// Usage:
//   Requests enter on req_* (valid/stall); one response per request leaves on rsp_*.
//   csr_write_enable with csr_active_count sets the active slot count (clamped 2..64);
//   the user must write it only while the unit is idle; the unit does not enforce this.
//   The swap walks all slots through a 3-stage pipeline (slot read, row read,
//   accumulate); evaluation walks each slot pair once on the single slot read port.
//   One request is in work at a time; the next request is taken while a finished
//   response waits in the output register.
//   Reset clears the cost, the sequencer, the output valid flag and the row valid
//   bits (influence matrix reads as all zero); slots stay undefined until written.
//   While rsp_stall is high the response holds and the next result waits in the
//   sequencer.
module ordering_swap_local_search_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [ossl_pkg::CNT_W-1:0]  csr_active_count,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_opcode,
   input  logic [ossl_pkg::VAR_W-1:0]  req_index_a,
   input  logic [ossl_pkg::VAR_W-1:0]  req_index_b,
   input  logic                        req_bit_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ossl_pkg::COST_W-1:0] rsp_cost,
   output logic                        rsp_accepted,
   output logic [ossl_pkg::VAR_W-1:0]  rsp_read_variable,
   output logic                        rsp_bad_index
);
   import ossl_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    active_ff;
   logic [COST_W-1:0]   cost_ff;
   logic [VAR_W-1:0]    a_ff, b_ff, x_ff, y_ff, v2_ff;
   logic                bit_ff;
   logic [CNT_W-1:0]    p_ff, q_ff, i_ff, j_ff, k_ff, k1_ff, k2_ff;
   logic                pend_ff, s1_ff, s2_ff;
   logic [VAR_W-1:0]    pd_ff;
   logic [COST_W-1:0]   acc_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [NUM_VARS-1:0] row_x_ff, row_y_ff;
   logic                res_acc_ff, res_bad_ff;
   logic [VAR_W-1:0]    res_readv_ff;

   logic                rsp_valid_ff;
   logic [COST_W-1:0]   rsp_cost_ff;
   logic                rsp_acc_ff, rsp_bad_ff;
   logic [VAR_W-1:0]    rsp_readv_ff;

   row_wr_type          row_wr;
   slot_wr_type         slot_wr;
   logic                row_re, slot_re;
   logic [VAR_W-1:0]    row_raddr, slot_raddr;
   logic [NUM_VARS-1:0] row_rdata;
   logic [VAR_W-1:0]    slot_rdata;

   logic                accept, req_bad, rsp_free, load_rsp;
   logic [CNT_W-1:0]    ext_a, ext_b;
   logic                ev_done, sw_done;
   logic signed [DELTA_W-1:0] delta_step, final_delta;
   logic [SQ_W-1:0]     sq_p, sq_q, sq_pq;
   logic                t_py, t_qx, t_px, t_qy, lt_p, lt_q;

   ossl_infl_ram u_infl (
      .clock   (clock),
      .reset   (reset),
      .row_wr  (row_wr),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   ossl_slot_ram u_slot (
      .clock   (clock),
      .slot_wr (slot_wr),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ext_a     = {1'b0, req_index_a};
   assign ext_b     = {1'b0, req_index_b};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == S_RESP) && rsp_free;

   always_comb begin
      case (req_opcode)
         OP_WRITE_SLOT, OP_READ_SLOT: req_bad = (ext_a >= active_ff);
         OP_SWAP:                     req_bad = (ext_a >= active_ff) || (ext_b >= active_ff);
         default:                     req_bad = 1'b0;
      endcase
   end

   assign ev_done = (j_ff >= active_ff) && !pend_ff;
   assign sw_done = (k_ff >= active_ff) && !s1_ff && !s2_ff;

   // swap delta term for the slot leaving the row-read stage, and the final p/q pair term
   always_comb begin
      lt_p = (k2_ff < p_ff);
      lt_q = (k2_ff < q_ff);
      sq_p = square_dist(abs_diff(k2_ff, p_ff));
      sq_q = square_dist(abs_diff(k2_ff, q_ff));
      t_py = lt_p ? row_rdata[y_ff] : row_y_ff[v2_ff];
      t_qx = lt_q ? row_rdata[x_ff] : row_x_ff[v2_ff];
      t_px = lt_p ? row_rdata[x_ff] : row_x_ff[v2_ff];
      t_qy = lt_q ? row_rdata[y_ff] : row_y_ff[v2_ff];
      delta_step = delta_ff
                 + (t_py ? DELTA_W'(sq_p) : '0) + (t_qx ? DELTA_W'(sq_q) : '0)
                 - (t_px ? DELTA_W'(sq_p) : '0) - (t_qy ? DELTA_W'(sq_q) : '0);
      sq_pq = square_dist(abs_diff(q_ff, p_ff));
      final_delta = delta_ff
                  + (row_y_ff[x_ff] ? DELTA_W'(sq_pq) : '0)
                  - (row_x_ff[y_ff] ? DELTA_W'(sq_pq) : '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_bad) begin
                  state_in = S_RESP;
               end else begin
                  case (req_opcode)
                     OP_SET_BIT:   state_in = S_ROW_WR;
                     OP_EVAL:      state_in = S_EV_ORD;
                     OP_SWAP:      state_in = (req_index_a == req_index_b) ? S_RESP : S_SW_RP;
                     OP_READ_SLOT: state_in = S_SLOT_RD;
                     default:      state_in = S_RESP;
                  endcase
               end
            end
         end
         S_ROW_WR:  state_in = S_RESP;
         S_SLOT_RD: state_in = S_RESP;
         S_EV_ORD:  state_in = S_EV_ROW;
         S_EV_ROW:  state_in = S_EV_WALK;
         S_EV_WALK: begin
            if (ev_done) begin
               state_in = (i_ff + CNT_W'(2) >= active_ff) ? S_RESP : S_EV_ORD;
            end
         end
         S_SW_RP:   state_in = S_SW_RQ;
         S_SW_RQ:   state_in = S_SW_RX;
         S_SW_RX:   state_in = S_SW_RY;
         S_SW_RY:   state_in = S_SW_LY;
         S_SW_LY:   state_in = S_SW_WALK;
         S_SW_WALK: state_in = sw_done ? S_SW_FIN : S_SW_WALK;
         S_SW_FIN:  state_in = final_delta[DELTA_W-1] ? S_SW_WP : S_RESP;
         S_SW_WP:   state_in = S_SW_WQ;
         S_SW_WQ:   state_in = S_RESP;
         S_RESP:    state_in = rsp_free ? S_IDLE : S_RESP;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      row_wr     = '0;
      slot_wr    = '0;
      row_re     = 1'b0;
      slot_re    = 1'b0;
      row_raddr  = a_ff;
      slot_raddr = a_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_bad) begin
               row_re     = (req_opcode == OP_SET_BIT);
               row_raddr  = req_index_a;
               slot_re    = (req_opcode == OP_READ_SLOT);
               slot_raddr = req_index_a;
               slot_wr.en   = (req_opcode == OP_WRITE_SLOT);
               slot_wr.addr = req_index_a;
               slot_wr.data = req_index_b;
            end
         end
         S_ROW_WR: begin
            row_wr.en   = 1'b1;
            row_wr.addr = a_ff;
            row_wr.data = row_rdata;
            row_wr.data[b_ff] = bit_ff;
         end
         S_EV_ORD: begin
            slot_re    = 1'b1;
            slot_raddr = i_ff[VAR_W-1:0];
         end
         S_EV_ROW: begin
            row_re    = 1'b1;
            row_raddr = slot_rdata;
         end
         S_EV_WALK: begin
            slot_re    = (j_ff < active_ff);
            slot_raddr = j_ff[VAR_W-1:0];
         end
         S_SW_RP: begin
            slot_re    = 1'b1;
            slot_raddr = p_ff[VAR_W-1:0];
         end
         S_SW_RQ: begin
            slot_re    = 1'b1;
            slot_raddr = q_ff[VAR_W-1:0];
         end
         S_SW_RX: begin
            row_re    = 1'b1;
            row_raddr = x_ff;
         end
         S_SW_RY: begin
            row_re    = 1'b1;
            row_raddr = y_ff;
         end
         S_SW_WALK: begin
            slot_re    = (k_ff < active_ff);
            slot_raddr = k_ff[VAR_W-1:0];
            row_re     = s1_ff;
            row_raddr  = slot_rdata;
         end
         S_SW_WP: begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = p_ff[VAR_W-1:0];
            slot_wr.data = y_ff;
         end
         S_SW_WQ: begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = q_ff[VAR_W-1:0];
            slot_wr.data = x_ff;
         end
         default: begin
            row_re = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= ACTIVE_MAX;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_active_count < ACTIVE_MIN) begin
               active_ff <= ACTIVE_MIN;
            end else if (csr_active_count > ACTIVE_MAX) begin
               active_ff <= ACTIVE_MAX;
            end else begin
               active_ff <= csr_active_count;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_EV_ROW:  pend_ff <= 1'b0;
            S_EV_WALK: begin
               pend_ff <= (j_ff < active_ff);
               if (ev_done && (i_ff + CNT_W'(2) >= active_ff)) begin
                  cost_ff <= acc_ff;
               end
            end
            S_SW_LY: begin
               s1_ff <= 1'b0;
               s2_ff <= 1'b0;
            end
            S_SW_WALK: begin
               s1_ff <= (k_ff < active_ff) && (k_ff != p_ff) && (k_ff != q_ff);
               s2_ff <= s1_ff;
            end
            S_SW_FIN: begin
               if (final_delta[DELTA_W-1]) begin
                  cost_ff <= cost_ff + COST_W'(final_delta);
               end
            end
            default: begin
               pend_ff <= pend_ff;
            end
         endcase
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_cost_ff  <= cost_ff;
         rsp_acc_ff   <= res_acc_ff;
         rsp_bad_ff   <= res_bad_ff;
         rsp_readv_ff <= res_readv_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               a_ff         <= req_index_a;
               b_ff         <= req_index_b;
               bit_ff       <= req_bit_value;
               p_ff         <= (ext_a < ext_b) ? ext_a : ext_b;
               q_ff         <= (ext_a < ext_b) ? ext_b : ext_a;
               i_ff         <= '0;
               acc_ff       <= '0;
               delta_ff     <= '0;
               res_acc_ff   <= 1'b0;
               res_bad_ff   <= req_bad;
               res_readv_ff <= '0;
            end
         end
         S_SLOT_RD: res_readv_ff <= slot_rdata;
         S_EV_ROW:  j_ff <= i_ff + CNT_W'(1);
         S_EV_WALK: begin
            pd_ff <= abs_diff(j_ff, i_ff);
            if (j_ff < active_ff) begin
               j_ff <= j_ff + CNT_W'(1);
            end
            if (pend_ff && row_rdata[slot_rdata]) begin
               acc_ff <= acc_ff + COST_W'(square_dist(pd_ff));
            end
            if (ev_done) begin
               i_ff <= i_ff + CNT_W'(1);
            end
         end
         S_SW_RQ:   x_ff <= slot_rdata;
         S_SW_RX:   y_ff <= slot_rdata;
         S_SW_RY:   row_x_ff <= row_rdata;
         S_SW_LY: begin
            row_y_ff <= row_rdata;
            k_ff     <= '0;
         end
         S_SW_WALK: begin
            if (k_ff < active_ff) begin
               k_ff <= k_ff + CNT_W'(1);
            end
            k1_ff <= k_ff;
            k2_ff <= k1_ff;
            v2_ff <= slot_rdata;
            if (s2_ff) begin
               delta_ff <= delta_step;
            end
         end
         S_SW_FIN:  res_acc_ff <= final_delta[DELTA_W-1];
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cost          = rsp_cost_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_bad_index     = rsp_bad_ff;
   assign rsp_read_variable = rsp_readv_ff;

   a_no_accept_when_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_bad_index))
      else $error("swap reported accepted on an ignored request");

   a_slot_write_states: assert property (@(posedge clock) disable iff (reset)
      slot_wr.en |-> (state_ff == S_IDLE || state_ff == S_SW_WP || state_ff == S_SW_WQ))
      else $error("slot store written outside a write step");

   a_swap_applies_both: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_WP) |=> (state_ff == S_SW_WQ))
      else $error("swap write-back split");

   a_cost_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(cost_ff))
      else $error("cost changed while idle");

endmodule
